// ===== design/fm0_pkg.sv =====
package fm0_pkg;

    // Fixed field widths
    localparam int TARI_W     = 16;
    localparam int TMO_W      = 24;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_TARI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO  = 1'b1;

    // Register reset values
    localparam logic [TARI_W-1:0] TARI_RST = 16'd500;
    localparam logic [TMO_W-1:0]  TMO_RST  = 24'd100000;

    // Bounds: time*2000 compared against k*Tari
    localparam logic [10:0] TIME_SCALE = 11'd2000;
    localparam logic [6:0]  K_HALF_LO  = 7'd7;
    localparam logic [6:0]  K_ONE_LO   = 7'd13;
    localparam logic [6:0]  K_ONE_HI   = 7'd27;
    localparam logic [6:0]  K_END      = 7'd120;

    // Opcode of an input word
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // Classification queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One classified word
    typedef struct packed {
        logic tick;      // tick word, otherwise edge word
        logic one;       // 0.65 .. 1.35 Tari
        logic half;      // 0.35 .. 0.65 Tari
        logic past_end;  // above 6 Tari
        logic timeout;   // above start timeout
    } t_cls;

endpackage

// ===== design/fm0_front.sv =====
module fm0_front #(
    parameter int TIME_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [TIME_BITS-1:0]          i_time_value,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fm0_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fm0_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // classified words to queue
    output logic                          o_push,
    output fm0_pkg::t_cls                 o_cls,
    input  logic                          i_full
);

    // Compare width: scaled time or 120*Tari, whichever is wider
    localparam int SW = TIME_BITS + 11;
    localparam int CW = (SW > fm0_pkg::TARI_W + 7) ? SW : fm0_pkg::TARI_W + 7;
    localparam int TW = (TIME_BITS > fm0_pkg::TMO_W) ? TIME_BITS : fm0_pkg::TMO_W;

    logic [fm0_pkg::TARI_W-1:0] r_tari;
    logic [fm0_pkg::TMO_W-1:0]  r_tmo;

    // stage A: raw word
    logic                 r_a_vld;
    logic                 r_a_tick;
    logic [TIME_BITS-1:0] r_a_time;

    // stage B: scaled time and bounds
    logic          r_b_vld;
    logic          r_b_tick;
    logic          r_b_tmo;
    logic [CW-1:0] r_b_st;
    logic [CW-1:0] r_b_k7;
    logic [CW-1:0] r_b_k13;
    logic [CW-1:0] r_b_k27;
    logic [CW-1:0] r_b_k120;

    logic          en_a;
    logic          en_b;
    logic          accept;
    logic [CW-1:0] tari_x;
    logic [CW-1:0] n_st;
    logic          n_tmo;

    // config port never blocks
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tari <= fm0_pkg::TARI_RST;
            r_tmo  <= fm0_pkg::TMO_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fm0_pkg::CFG_TARI: r_tari <= i_cfg_data[fm0_pkg::TARI_W-1:0];
                fm0_pkg::CFG_TMO:  r_tmo  <= i_cfg_data[fm0_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign o_push     = r_b_vld && !i_full;
    assign en_b       = !r_b_vld || !i_full;
    assign en_a       = !r_a_vld || en_b;
    assign o_in_stall = !en_a;
    assign accept     = i_in_valid && en_a;

    // constant products
    assign tari_x = CW'(r_tari);
    assign n_st   = CW'(r_a_time) * CW'(fm0_pkg::TIME_SCALE);
    assign n_tmo  = TW'(r_a_time) > TW'(r_tmo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (en_a) r_a_vld <= accept;
            if (en_b) r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_tick <= (i_opcode == fm0_pkg::OP_TICK);
            r_a_time <= i_time_value;
        end
        if (en_b && r_a_vld) begin
            r_b_tick <= r_a_tick;
            r_b_tmo  <= n_tmo;
            r_b_st   <= n_st;
            r_b_k7   <= tari_x * CW'(fm0_pkg::K_HALF_LO);
            r_b_k13  <= tari_x * CW'(fm0_pkg::K_ONE_LO);
            r_b_k27  <= tari_x * CW'(fm0_pkg::K_ONE_HI);
            r_b_k120 <= tari_x * CW'(fm0_pkg::K_END);
        end
    end

    // range compares, all bounds exclusive
    always_comb begin
        o_cls.tick     = r_b_tick;
        o_cls.one      = (r_b_st > r_b_k13) && (r_b_st < r_b_k27);
        o_cls.half     = (r_b_st > r_b_k7) && (r_b_st < r_b_k13);
        o_cls.past_end = r_b_st > r_b_k120;
        o_cls.timeout  = r_b_tmo;
    end

endmodule

// ===== design/fm0_queue.sv =====
module fm0_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fm0_pkg::t_cls i_cls,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output fm0_pkg::t_cls o_cls
);

    fm0_pkg::t_cls             r_mem [fm0_pkg::Q_DEPTH];
    logic [fm0_pkg::Q_AW-1:0]  r_wp;
    logic [fm0_pkg::Q_AW-1:0]  r_rp;
    logic [fm0_pkg::Q_AW:0]    r_cnt;

    assign o_full = (r_cnt == (fm0_pkg::Q_AW+1)'(fm0_pkg::Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_cls  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cls;
    end

endmodule

// ===== design/fm0_back.sv =====
module fm0_back #(
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // classified words from queue
    input  logic                        i_q_vld,
    input  fm0_pkg::t_cls               i_cls,
    output logic                        o_q_pop,
    // result words
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_status,
    output logic [PAYLOAD_BITS-1:0]     o_payload,
    output logic [fm0_pkg::CNT_W-1:0]   o_bit_count
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_READ,
        PH_HALF
    } t_phase;

    localparam logic [fm0_pkg::CNT_W-1:0] CNT_MAX = fm0_pkg::CNT_W'(PAYLOAD_BITS + 1);

    t_phase                      r_phase, n_phase;
    logic [PAYLOAD_BITS-1:0]     r_shift, n_shift;
    logic [fm0_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_last, n_last;
    logic                        r_out_vld, n_out_vld;
    logic                        r_status, n_status;
    logic [PAYLOAD_BITS-1:0]     r_payload, n_payload;
    logic [fm0_pkg::CNT_W-1:0]   r_count, n_count;

    logic pop;
    logic do_shift;
    logic shift_bit;
    logic do_ok;
    logic do_err;

    // a word is consumed only when the output register can take a result
    assign pop     = i_q_vld && (!r_out_vld || !i_out_stall);
    assign o_q_pop = pop;

    // decode one classified word
    always_comb begin
        do_shift  = 1'b0;
        shift_bit = 1'b0;
        do_ok     = 1'b0;
        do_err    = 1'b0;
        n_phase   = r_phase;
        if (pop) begin
            unique case (r_phase)
                PH_READ: begin
                    if (!i_cls.tick) begin
                        if (i_cls.one) begin
                            do_shift  = 1'b1;
                            shift_bit = 1'b1;
                        end else if (i_cls.half) begin
                            n_phase = PH_HALF;
                        end else begin
                            do_err = 1'b1;
                        end
                    end else if (i_cls.past_end) begin
                        if (r_last && (r_cnt != '0)) do_ok  = 1'b1;
                        else                         do_err = 1'b1;
                    end
                end
                PH_HALF: begin
                    if (!i_cls.tick) begin
                        if (i_cls.half) do_shift = 1'b1;
                        else            do_err   = 1'b1;
                    end
                end
                default: begin
                    if (!i_cls.tick)         n_phase = PH_READ;
                    else if (i_cls.timeout)  do_err  = 1'b1;
                end
            endcase
            // a shifted bit resumes reading; a result goes back to the start
            if (do_shift)        n_phase = PH_READ;
            if (do_ok || do_err) n_phase = PH_WAIT;
        end
    end

    // frame state and result register
    always_comb begin
        n_shift   = r_shift;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_out_vld = r_out_vld && i_out_stall;
        n_status  = r_status;
        n_payload = r_payload;
        n_count   = r_count;
        if (do_shift) begin
            n_shift = {r_shift[PAYLOAD_BITS-2:0], shift_bit};
            n_cnt   = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
            n_last  = shift_bit;
        end
        if (do_ok || do_err) begin
            n_out_vld = 1'b1;
            n_status  = do_ok ? fm0_pkg::ST_OK : fm0_pkg::ST_ERR;
            n_payload = do_ok ? {1'b0, r_shift[PAYLOAD_BITS-1:1]} : '0;
            n_count   = do_ok ? r_cnt - 1'b1 : '0;
            // back to the start state
            n_shift   = '0;
            n_cnt     = '0;
            n_last    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_shift   <= '0;
            r_cnt     <= '0;
            r_last    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_out_vld <= n_out_vld;
        end
        r_status  <= n_status;
        r_payload <= n_payload;
        r_count   <= n_count;
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_status;
    assign o_payload   = r_payload;
    assign o_bit_count = r_count;

endmodule

// ===== design/fm0_edge_interval_decoder_top.sv =====
// FM0 decoder driven by measured edge intervals.
// Input channel (i_in_valid / o_in_stall): each word is an edge event with the
// interval since the previous edge (i_opcode = 0) or a tick with the time
// since the last edge (i_opcode = 1). Output channel (o_out_valid /
// i_out_stall): one word per frame, with status, payload (newest bit in bit 0)
// and bit count; on error payload and count are zero.
// Config port (i_cfg_valid / o_cfg_ready): index 0 is tari_length, index 1 is
// start_timeout; always ready; write only while no word is in flight.
// Throughput: one input word per cycle while o_in_stall is low. The front
// pipeline (scale and bound products, then range compares) feeds a 4-entry
// queue; the back decoder takes one classified word per cycle while its
// output register can take a result; the frame result is registered there.
// When the receiver stalls, the result stays in the output register; the
// back stops popping the queue, the queue fills, and then o_in_stall rises.
// Reset (i_rst_n low, synchronous) restores the registers to 500 and 100000,
// empties the pipeline and queue, and puts the decoder back to waiting for
// the first edge. No clearing pass is needed.
module fm0_edge_interval_decoder_top #(
    parameter int PAYLOAD_BITS = 64,
    parameter int TIME_BITS    = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [TIME_BITS-1:0]            i_time_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_status,
    output logic [PAYLOAD_BITS-1:0]         o_payload,
    output logic [fm0_pkg::CNT_W-1:0]       o_bit_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fm0_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fm0_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic          push;
    logic          full;
    logic          pop;
    logic          q_vld;
    fm0_pkg::t_cls front_cls;
    fm0_pkg::t_cls back_cls;

    fm0_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_time_value (i_time_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_cls        (front_cls),
        .i_full       (full)
    );

    fm0_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (front_cls),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_cls   (back_cls)
    );

    fm0_back #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (q_vld),
        .i_cls       (back_cls),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_payload   (o_payload),
        .o_bit_count (o_bit_count)
    );

endmodule
